### design/rft_pkg.sv
package rft_pkg;

   localparam int MAX_LEN   = 56;
   localparam int MAX_RAILS = 8;

   localparam int CHAR_WIDTH      = 8;
   localparam int COUNT_WIDTH     = 6;
   localparam int RAIL_WIDTH      = 3;
   localparam int TOTAL_WIDTH     = 4;
   localparam int RCOUNT_WIDTH    = 4;
   localparam int CSR_DATA_WIDTH  = 4;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CHAR_WIDTH-1:0] SPACE_CHAR = 8'h20;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RAIL_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION  = 1'b1;

   localparam logic [RCOUNT_WIDTH-1:0] RAIL_COUNT_RESET = 4'd3;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] in_char;
      logic                  in_last;
   } rft_req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] out_char;
      logic                  out_last;
      logic                  error;
   } rft_rsp_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_SPACE = 2'd1,
      KIND_ERR   = 2'd2
   } rft_kind_type;

   typedef struct packed {
      logic         load;
      logic         clear;
      logic         rd_enc;
      logic         rd_dec;
      logic         enc_step;
      logic         enc_next_rail;
      logic         dec_adv;
      logic         dec_mode;
      rft_kind_type kind;
   } rft_cmd_type;

   typedef struct packed {
      logic direction;
      logic ovf_now;
      logic load_empty;
      logic enc_has;
      logic enc_last_rail;
      logic dec_err;
      logic dec_last;
   } rft_status_type;

endpackage

### design/rail_fence_transposer.sv
// Rail fence transposer. Message bytes are taken one per cycle into a 56-byte
// buffer; the transaction marked last starts emission (unless it is a decrypt
// space that finds the buffer empty, which only clears the run) and no new byte
// is taken until the final result transaction of the run has been accepted.
// Each output byte is selected and read in a scan state, through the buffer's
// single registered read port, and presented in a show state that holds until
// the receiver accepts it; the rail-closing spaces of encrypt skip the read. An
// encrypt run of n bytes on R rails gives n+R results. An exhausted rail group
// gives its error result from the scan state too, while an overflow error result
// is presented in the cycle after the last byte. No clearing pass follows reset.
module rail_fence_transposer
   import rft_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rft_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rft_rsp_type                rsp_data,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   rft_cmd_type    cmd;
   rft_status_type status;

   rft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.in_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rft_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .cmd          (cmd),
      .status       (status)
   );

   // loading and emission never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result channels active together");

   a_error_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error) |-> rsp_data.out_last)
      else $error("error result does not end the run");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.out_last) |=> (req_ready && !rsp_valid))
      else $error("block not ready after final result transaction");

endmodule

### design/rft_ctrl.sv
module rft_ctrl
   import rft_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  rft_status_type status,
   output rft_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ENC_SCAN,
      ST_DEC_SCAN,
      ST_SHOW_CHAR,
      ST_SHOW_SPACE,
      ST_SHOW_ERR
   } state_type;

   state_type state_ff, state_in;
   logic      dec_mode_ff, dec_mode_in;

   always_comb begin
      state_in     = state_ff;
      dec_mode_in  = dec_mode_ff;
      cmd          = '0;
      cmd.dec_mode = dec_mode_ff;
      cmd.kind     = KIND_CHAR;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  if (status.ovf_now) begin
                     state_in = ST_SHOW_ERR;
                  end else if (!status.direction) begin
                     dec_mode_in = 1'b0;
                     state_in    = ST_ENC_SCAN;
                  end else if (status.load_empty) begin
                     cmd.clear = 1'b1;
                  end else begin
                     dec_mode_in = 1'b1;
                     state_in    = ST_DEC_SCAN;
                  end
               end
            end
         end
         ST_ENC_SCAN: begin
            if (status.enc_has) begin
               cmd.rd_enc = 1'b1;
               state_in   = ST_SHOW_CHAR;
            end else begin
               state_in = ST_SHOW_SPACE;
            end
         end
         ST_DEC_SCAN: begin
            if (status.dec_err) begin
               state_in = ST_SHOW_ERR;
            end else begin
               cmd.rd_dec = 1'b1;
               state_in   = ST_SHOW_CHAR;
            end
         end
         ST_SHOW_CHAR: begin
            cmd.kind = KIND_CHAR;
            if (rsp_ready) begin
               if (dec_mode_ff) begin
                  if (status.dec_last) begin
                     cmd.clear = 1'b1;
                     state_in  = ST_LOAD;
                  end else begin
                     cmd.dec_adv = 1'b1;
                     state_in    = ST_DEC_SCAN;
                  end
               end else begin
                  cmd.enc_step = 1'b1;
                  state_in     = ST_ENC_SCAN;
               end
            end
         end
         ST_SHOW_SPACE: begin
            cmd.kind = KIND_SPACE;
            if (rsp_ready) begin
               if (status.enc_last_rail) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  cmd.enc_next_rail = 1'b1;
                  state_in          = ST_ENC_SCAN;
               end
            end
         end
         ST_SHOW_ERR: begin
            cmd.kind = KIND_ERR;
            if (rsp_ready) begin
               cmd.clear = 1'b1;
               state_in  = ST_LOAD;
            end
         end
      endcase
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_SHOW_CHAR) || (state_ff == ST_SHOW_SPACE) ||
                      (state_ff == ST_SHOW_ERR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         dec_mode_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         dec_mode_ff <= dec_mode_in;
      end
   end

endmodule

### design/rft_datapath.sv
module rft_datapath
   import rft_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  rft_req_type                req_data,
   output rft_rsp_type                rsp_data,
   input  rft_cmd_type                cmd,
   output rft_status_type             status
);

   logic [CHAR_WIDTH-1:0]   mem [MAX_LEN];
   logic [CHAR_WIDTH-1:0]   mem_q_ff;

   logic [RCOUNT_WIDTH-1:0] rail_count_ff;
   logic                    dir_ff;

   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [TOTAL_WIDTH-1:0]  gt_ff;
   logic [COUNT_WIDTH-1:0]  start_ff  [MAX_RAILS];
   logic [COUNT_WIDTH-1:0]  stop_ff   [MAX_RAILS];
   logic [COUNT_WIDTH-1:0]  cursor_ff [MAX_RAILS];
   logic                    ovf_ff;

   logic [RAIL_WIDTH-1:0]   rail_ff;
   logic [COUNT_WIDTH:0]    idx_ff;
   logic                    tog_ff;
   logic [COUNT_WIDTH-1:0]  pos_ff;
   logic                    down_ff;

   logic [RCOUNT_WIDTH-1:0] rails;
   logic [RAIL_WIDTH-1:0]   rail_max;
   logic [4:0]              period;
   logic [4:0]              twice_rail;
   logic [4:0]              step;
   logic [COUNT_WIDTH:0]    idx_step;
   logic [COUNT_WIDTH:0]    dec_idx;
   logic [COUNT_WIDTH-1:0]  dec_end;
   logic                    is_gap;
   logic                    full;
   logic                    store_en;
   logic [COUNT_WIDTH-1:0]  rd_addr;

   // clamp rails to the supported range
   always_comb begin
      if (rail_count_ff < RCOUNT_WIDTH'(2)) begin
         rails = RCOUNT_WIDTH'(2);
      end else if (rail_count_ff > RCOUNT_WIDTH'(MAX_RAILS)) begin
         rails = RCOUNT_WIDTH'(MAX_RAILS);
      end else begin
         rails = rail_count_ff;
      end
   end

   assign rail_max   = RAIL_WIDTH'(rails - RCOUNT_WIDTH'(1));
   assign period     = {rails, 1'b0} - 5'd2;
   assign twice_rail = {1'b0, rail_ff, 1'b0};

   // gaps inside the zigzag alternate between the two sides of a rail
   always_comb begin
      step = tog_ff ? twice_rail : (period - twice_rail);
      if (step == 5'd0) begin
         step = period;
      end
   end

   assign idx_step = idx_ff + {2'b00, step};

   assign dec_idx = {1'b0, start_ff[rail_ff]} + {1'b0, cursor_ff[rail_ff]};
   assign dec_end = ({1'b0, rail_ff} < gt_ff) ? stop_ff[rail_ff] : count_ff;

   assign is_gap   = dir_ff && (req_data.in_char == SPACE_CHAR);
   assign full     = (count_ff == COUNT_WIDTH'(MAX_LEN));
   assign store_en = cmd.load && !cmd.clear && !is_gap && !full;
   assign rd_addr  = cmd.rd_dec ? dec_idx[COUNT_WIDTH-1:0] : idx_ff[COUNT_WIDTH-1:0];

   always_comb begin
      status.direction     = dir_ff;
      status.ovf_now       = ovf_ff || (!is_gap && full);
      status.load_empty    = is_gap && (count_ff == '0);
      status.enc_has       = idx_ff < {1'b0, count_ff};
      status.enc_last_rail = (rail_ff == rail_max);
      status.dec_err       = (dec_idx >= {1'b0, dec_end}) ||
                             (dec_idx >= (COUNT_WIDTH+1)'(MAX_LEN));
      status.dec_last      = ({1'b0, pos_ff} + 7'd1) == {1'b0, count_ff};
   end

   always_comb begin
      unique case (cmd.kind)
         KIND_CHAR: begin
            rsp_data.out_char = mem_q_ff;
            rsp_data.out_last = cmd.dec_mode && status.dec_last;
            rsp_data.error    = 1'b0;
         end
         KIND_SPACE: begin
            rsp_data.out_char = SPACE_CHAR;
            rsp_data.out_last = status.enc_last_rail;
            rsp_data.error    = 1'b0;
         end
         default: begin
            rsp_data.out_char = '0;
            rsp_data.out_last = 1'b1;
            rsp_data.error    = 1'b1;
         end
      endcase
   end

   // message buffer
   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[count_ff] <= req_data.in_char;
      end
      if (cmd.rd_enc || cmd.rd_dec) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rail_count_ff <= RAIL_COUNT_RESET;
         dir_ff        <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_RAIL_COUNT: rail_count_ff <= csr_wdata;
            CSR_DIRECTION:  dir_ff        <= csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         gt_ff    <= '0;
         ovf_ff   <= 1'b0;
         for (int i = 0; i < MAX_RAILS; i++) begin
            start_ff[i]  <= '0;
            stop_ff[i]   <= '0;
            cursor_ff[i] <= '0;
         end
         rail_ff <= '0;
         idx_ff  <= '0;
         tog_ff  <= 1'b0;
         pos_ff  <= '0;
         down_ff <= 1'b1;
      end else begin
         if (cmd.load) begin
            if (is_gap) begin
               if (gt_ff < TOTAL_WIDTH'(MAX_RAILS)) begin
                  stop_ff[gt_ff[RAIL_WIDTH-1:0]] <= count_ff;
                  if (gt_ff < TOTAL_WIDTH'(MAX_RAILS - 1)) begin
                     start_ff[gt_ff[RAIL_WIDTH-1:0] + RAIL_WIDTH'(1)] <= count_ff;
                  end
                  gt_ff <= gt_ff + TOTAL_WIDTH'(1);
               end
            end else if (!full) begin
               count_ff <= count_ff + COUNT_WIDTH'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.rd_dec) begin
            cursor_ff[rail_ff] <= cursor_ff[rail_ff] + COUNT_WIDTH'(1);
         end
         if (cmd.enc_step) begin
            idx_ff <= idx_step;
            tog_ff <= ~tog_ff;
         end else if (cmd.enc_next_rail) begin
            rail_ff <= rail_ff + RAIL_WIDTH'(1);
            idx_ff  <= {4'b0000, rail_ff + RAIL_WIDTH'(1)};
            tog_ff  <= 1'b0;
         end else if (cmd.dec_adv) begin
            pos_ff <= pos_ff + COUNT_WIDTH'(1);
            if (down_ff) begin
               if (rail_ff == rail_max) begin
                  rail_ff <= rail_ff - RAIL_WIDTH'(1);
                  down_ff <= 1'b0;
               end else begin
                  rail_ff <= rail_ff + RAIL_WIDTH'(1);
               end
            end else begin
               if (rail_ff == '0) begin
                  rail_ff <= rail_ff + RAIL_WIDTH'(1);
                  down_ff <= 1'b1;
               end else begin
                  rail_ff <= rail_ff - RAIL_WIDTH'(1);
               end
            end
         end
      end
   end

endmodule

### tb/sv/rft_transpose_checker.sv
module rft_transpose_checker
   import rft_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  rft_req_type                req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  rft_rsp_type                rsp_data,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                         mismatch_count,
   output int                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [CHAR_WIDTH-1:0]   char_buf [MAX_LEN];
   int unsigned             buf_fill;
   int unsigned             grp_begin [MAX_RAILS+1];
   int unsigned             grp_seen;
   int unsigned             grp_taken [MAX_RAILS];
   bit                      buf_overrun;
   logic [RCOUNT_WIDTH-1:0] rails_reg;
   logic                    decrypting;
   rft_rsp_type             expected_bytes [$];
   int                      errs;

   function automatic int unsigned rail_at(int unsigned pos, int unsigned rails);
      int unsigned period;
      int unsigned phase;
      period = 2 * rails - 2;
      phase  = pos % period;
      return (phase < rails) ? phase : period - phase;
   endfunction

   function automatic void expect_byte(logic [CHAR_WIDTH-1:0] ch, logic last, logic err);
      rft_rsp_type item;
      item.out_char = ch;
      item.out_last = last;
      item.error    = err;
      expected_bytes.insert(expected_bytes.size(), item);
   endfunction

   function automatic void restart_run();
      buf_fill = 0;
      foreach (grp_begin[g]) grp_begin[g] = 0;
      grp_seen = 0;
      foreach (grp_taken[g]) grp_taken[g] = 0;
      buf_overrun = 1'b0;
   endfunction

   // loads one byte and, on the last one, queues the whole transposed run or its error result
   function automatic void transpose_byte(rft_req_type t);
      int unsigned rails;
      int unsigned g;
      int unsigned i;
      int unsigned idx;
      int unsigned stop;
      rails = (rails_reg < 2) ? 2 : (rails_reg > MAX_RAILS) ? MAX_RAILS : rails_reg;
      if (decrypting && t.in_char == SPACE_CHAR) begin
         if (grp_seen < MAX_RAILS) begin
            grp_begin[grp_seen + 1] = buf_fill;
            grp_seen++;
         end
      end else if (buf_fill < MAX_LEN) begin
         char_buf[buf_fill] = t.in_char;
         buf_fill++;
      end else begin
         buf_overrun = 1'b1;
      end
      if (!t.in_last) return;
      if (buf_overrun) begin
         expect_byte('0, 1'b1, 1'b1);
      end else if (!decrypting) begin
         for (g = 0; g < rails; g++) begin
            for (i = 0; i < buf_fill; i++)
               if (rail_at(i, rails) == g) expect_byte(char_buf[i], 1'b0, 1'b0);
            expect_byte(SPACE_CHAR, g == rails - 1, 1'b0);
         end
      end else begin
         for (i = 0; i < buf_fill; i++) begin
            g    = rail_at(i, rails);
            stop = (g < grp_seen) ? grp_begin[g + 1] : buf_fill;
            idx  = grp_begin[g] + grp_taken[g];
            if (idx >= stop || idx >= MAX_LEN) begin
               expect_byte('0, 1'b1, 1'b1);
               break;
            end
            grp_taken[g]++;
            expect_byte(char_buf[idx], i + 1 == buf_fill, 1'b0);
         end
      end
      restart_run();
   endfunction

   always @(posedge clock) begin
      rft_rsp_type want;
      if (reset) begin
         restart_run();
         rails_reg  = RAIL_COUNT_RESET;
         decrypting = 1'b0;
         expected_bytes.delete();
         errs = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result transaction: out_char %02h out_last %0b error %0b",
                      rsp_data.out_char, rsp_data.out_last, rsp_data.error);
               errs++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.out_char !== want.out_char) begin
                  $error("out_char mismatch: expected %02h, actual %02h",
                         want.out_char, rsp_data.out_char);
                  errs++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last mismatch: expected %0b, actual %0b",
                         want.out_last, rsp_data.out_last);
                  errs++;
               end
               if (rsp_data.error !== want.error) begin
                  $error("error mismatch: expected %0b, actual %0b",
                         want.error, rsp_data.error);
                  errs++;
               end
            end
         end
         if (csr_write_en) begin
            if (csr_index == CSR_RAIL_COUNT) rails_reg = csr_wdata[RCOUNT_WIDTH-1:0];
            else if (csr_index == CSR_DIRECTION) decrypting = csr_wdata[0];
         end
         if (req_valid && req_ready) transpose_byte(req_data);
      end
      mismatch_count <= errs;
      outstanding    <= expected_bytes.size();
   end

endmodule

### tb/sv/tb_rail_fence_transposer.sv
module tb_rail_fence_transposer;
   timeunit 1ns;
   timeprecision 1ps;
   import rft_pkg::*;

   localparam logic DIR_ENCRYPT   = 1'b0;
   localparam logic DIR_DECRYPT   = 1'b1;
   localparam int   QUIET_LIMIT   = 2000;
   localparam int   SETTLE_CYCLES = 8;
   localparam int   ITEM_TARGET   = 130;

   typedef logic [CHAR_WIDTH-1:0] text_type [$];

   logic                       clock        = 1'b0;
   logic                       reset        = 1'b1;
   logic                       req_valid    = 1'b0;
   logic                       req_ready;
   rft_req_type                req_data     = '0;
   logic                       rsp_valid;
   logic                       rsp_ready    = 1'b0;
   rft_rsp_type                rsp_data;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index    = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata    = '0;

   int          mismatch_count;
   int          outstanding;
   int          rx_tick      = 0;
   int          quiet_cycles = 0;
   int          burst_left   = 0;
   bit          gapless      = 1'b0;
   int          msg_total    = 0;
   int          byte_total   = 0;
   int unsigned rails_now    = 3;
   logic        dir_now      = DIR_ENCRYPT;

   rail_fence_transposer dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   rft_transpose_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #5 clock = ~clock;

   // receiver stall pattern, cycling through four characters
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      case ((rx_tick / 97) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ((rx_tick % 7) < 3);
         default: rsp_ready <= ((rx_tick % 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(logic [CHAR_WIDTH-1:0] ch, logic last);
      req_data  <= '{in_char: ch, in_last: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      byte_total++;
      if (gapless || burst_left > 0) begin
         if (burst_left > 0) burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 7);
      end
   endtask

   task automatic send_message(text_type text);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
      msg_total++;
      gapless = ($urandom_range(0, 3) == 0);
   endtask

   // hold off until every queued result transaction is back
   task automatic drain();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(logic [RCOUNT_WIDTH-1:0] rails, logic dir);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_RAIL_COUNT;
      csr_wdata    <= rails;
      @(posedge clock);
      csr_index    <= CSR_DIRECTION;
      csr_wdata    <= CSR_DATA_WIDTH'(dir);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      rails_now = (rails < 2) ? 2 : (rails > MAX_RAILS) ? MAX_RAILS : rails;
      dir_now   = dir;
   endtask

   function automatic logic [CHAR_WIDTH-1:0] plain_char();
      logic [CHAR_WIDTH-1:0] c;
      do c = CHAR_WIDTH'($urandom_range(0, 255)); while (c == SPACE_CHAR);
      return c;
   endfunction

   function automatic text_type noise_text(int unsigned n);
      text_type t;
      repeat (n) t = {t, ($urandom_range(0, 3) == 0) ? SPACE_CHAR
                                                    : CHAR_WIDTH'($urandom_range(0, 255))};
      return t;
   endfunction

   // cipher-shaped input: one group per rail sized for an n-byte message
   function automatic text_type fence_text(int unsigned n, bit tail_space, bit broken);
      int unsigned fill [MAX_RAILS];
      int unsigned period;
      int unsigned phase;
      int unsigned a;
      int unsigned b;
      text_type    t;
      foreach (fill[g]) fill[g] = 0;
      period = 2 * rails_now - 2;
      for (int unsigned i = 0; i < n; i++) begin
         phase = i % period;
         fill[(phase < rails_now) ? phase : period - phase]++;
      end
      if (broken) begin
         a = $urandom_range(0, rails_now - 1);
         b = $urandom_range(0, rails_now - 1);
         if (fill[a] > 0) begin
            fill[a]--;
            fill[b]++;
         end
      end
      for (int unsigned g = 0; g < rails_now; g++) begin
         repeat (fill[g]) t = {t, plain_char()};
         if (g < rails_now - 1 || tail_space) t = {t, SPACE_CHAR};
      end
      return t;
   endfunction

   initial begin
      text_type                t;
      logic [RCOUNT_WIDTH-1:0] rails_pick;
      logic                    dir_pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_mode(RCOUNT_WIDTH'(2), DIR_ENCRYPT);
      t = {8'h00, 8'hFF, SPACE_CHAR, 8'h7F};
      send_message(t);
      drain();

      set_mode(RCOUNT_WIDTH'(2), DIR_DECRYPT);
      send_message(fence_text(3, 1'b1, 1'b0));
      t = {SPACE_CHAR};
      send_message(t);
      drain();

      // second rail group is empty
      set_mode(RCOUNT_WIDTH'(3), DIR_DECRYPT);
      t = {8'h41, 8'h42, SPACE_CHAR, SPACE_CHAR};
      send_message(t);
      drain();

      // spaces past the last rail
      set_mode(RCOUNT_WIDTH'(8), DIR_DECRYPT);
      t = {8'h5A};
      repeat (9) t = {t, SPACE_CHAR};
      send_message(t);
      drain();

      // direction flipped in the middle of a message
      set_mode(RCOUNT_WIDTH'(4), DIR_ENCRYPT);
      send_byte(8'h6D, 1'b0);
      send_byte(SPACE_CHAR, 1'b0);
      drain();
      set_mode(RCOUNT_WIDTH'(4), DIR_DECRYPT);
      send_byte(8'h6E, 1'b0);
      send_byte(SPACE_CHAR, 1'b0);
      send_byte(8'h6F, 1'b1);
      msg_total++;
      drain();

      set_mode(RCOUNT_WIDTH'(8), DIR_ENCRYPT);
      send_message(noise_text(MAX_LEN + 1));
      drain();

      while (byte_total < ITEM_TARGET) begin
         if ($urandom_range(0, 5) == 0)
            rails_pick = $urandom_range(0, 1) ? RCOUNT_WIDTH'($urandom_range(0, 1))
                                              : RCOUNT_WIDTH'($urandom_range(MAX_RAILS + 1, 15));
         else
            rails_pick = RCOUNT_WIDTH'($urandom_range(2, MAX_RAILS));
         dir_pick = 1'($urandom_range(0, 1));
         set_mode(rails_pick, dir_pick);
         repeat ($urandom_range(1, 4)) begin
            if (dir_now == DIR_ENCRYPT) begin
               t = noise_text($urandom_range(1, 10));
            end else begin
               case ($urandom_range(0, 9))
                  0: t = noise_text($urandom_range(1, 10));
                  1: t = fence_text($urandom_range(1, 12), $urandom_range(0, 1), 1'b1);
                  default: t = fence_text($urandom_range(1, 12), $urandom_range(0, 1), 1'b0);
               endcase
            end
            send_message(t);
            if ($urandom_range(0, 4) == 0) drain();
         end
         drain();
      end

      drain();
      $display("sent %0d messages (%0d bytes) with rail counts drawn from 0..15 in both",
               msg_total, byte_total);
      $display("directions, including overflow, malformed and empty decrypt runs");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
